>>> sv/ipcs_pkg.sv
// Shared types, constants and the ones-complement adder for the IP packet checksum block.
package ipcs_pkg;

    typedef enum logic [1:0] {
        MODE_IP   = 2'd0,
        MODE_ICMP = 2'd1,
        MODE_TCP  = 2'd2,
        MODE_UDP  = 2'd3
    } t_mode;

    localparam logic [15:0] PROTO_TCP   = 16'h0006;
    localparam logic [15:0] PROTO_UDP   = 16'h0011;
    localparam logic [15:0] MIN_LEN     = 16'd20;
    localparam logic [15:0] PAD_MASK    = 16'hFF00;

    localparam logic [14:0] IDX_LEN_WORD = 15'd1;
    localparam logic [14:0] IDX_PROTO    = 15'd4;
    localparam logic [14:0] IDX_PSEUDO_L = 15'd5;
    localparam logic [14:0] IDX_IP_LAST  = 15'd9;

    typedef struct packed {
        logic [1:0]  func;
        logic [15:0] pkt_word;
        logic        first;
    } t_item;

    typedef struct packed {
        logic        valid;
        logic [15:0] checksum;
        logic        length_error;
    } t_result;

    // 16-bit add with end-around carry; the result never exceeds 0xFFFF.
    function automatic logic [15:0] add_oc(input logic [15:0] a, input logic [15:0] w);
        logic [16:0] s;
        s = {1'b0, a} + {1'b0, w};
        return s[15:0] + {15'd0, s[16]};
    endfunction

endpackage

>>> sv/ipcs_engine.sv
// Checksum engine: per-packet state and the combinational word update.
module ipcs_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  ipcs_pkg::t_item i_item,
    output ipcs_pkg::t_result o_res
);

    logic [15:0]     r_acc,  n_acc;
    logic [14:0]     r_idx,  n_idx;
    logic [15:0]     r_tl,   n_tl;
    ipcs_pkg::t_mode r_mode, n_mode;
    logic            r_active, n_active;

    logic [15:0]     eff_acc, eff_tl, tl_now, v, acc_new, len_field;
    logic [14:0]     eff_idx, last;
    logic [16:0]     len_plus;
    logic [15:0]     half_words, last_w;
    ipcs_pkg::t_mode eff_mode;
    logic            eff_active, is_len_word, is_short, is_last, is_l4, count, done;

    always_comb begin
        eff_active = i_item.first | r_active;
        eff_mode   = i_item.first ? ipcs_pkg::t_mode'(i_item.func) : r_mode;
        eff_idx    = i_item.first ? 15'd0 : r_idx;
        eff_acc    = i_item.first ? 16'd0 : r_acc;
        eff_tl     = i_item.first ? 16'd0 : r_tl;

        is_len_word = (eff_idx == ipcs_pkg::IDX_LEN_WORD);
        tl_now      = is_len_word ? i_item.pkt_word : eff_tl;
        is_short    = is_len_word && (i_item.pkt_word < ipcs_pkg::MIN_LEN);

        // Last counted word index: length rounded up to whole words, minus one (fixed for IP mode).
        len_plus   = {1'b0, tl_now} + 17'd1;
        half_words = len_plus[16:1];
        last_w     = half_words - 16'd1;
        last       = (eff_mode == ipcs_pkg::MODE_IP) ? ipcs_pkg::IDX_IP_LAST : last_w[14:0];
        is_last    = (eff_idx != 15'd0) && (eff_idx == last);

        is_l4 = (eff_mode == ipcs_pkg::MODE_TCP) || (eff_mode == ipcs_pkg::MODE_UDP);
        count = !is_l4 || (eff_idx >= ipcs_pkg::IDX_PROTO);

        len_field = tl_now - ipcs_pkg::MIN_LEN;
        v = i_item.pkt_word;
        if (is_l4 && eff_idx == ipcs_pkg::IDX_PROTO) begin
            v = (eff_mode == ipcs_pkg::MODE_TCP) ? ipcs_pkg::PROTO_TCP : ipcs_pkg::PROTO_UDP;
        end else if (is_l4 && eff_idx == ipcs_pkg::IDX_PSEUDO_L) begin
            v = len_field;
        end
        if (is_last && eff_mode != ipcs_pkg::MODE_IP && tl_now[0]) begin
            v = v & ipcs_pkg::PAD_MASK;
        end

        acc_new = count ? ipcs_pkg::add_oc(eff_acc, v) : eff_acc;
        done    = is_short || is_last;

        o_res.valid        = i_en && eff_active && done;
        o_res.checksum     = is_short ? 16'd0 : ~acc_new;
        o_res.length_error = is_short;

        n_acc    = r_acc;
        n_idx    = r_idx;
        n_tl     = r_tl;
        n_mode   = r_mode;
        n_active = r_active;
        if (i_en && eff_active) begin
            n_acc    = acc_new;
            n_idx    = eff_idx + 15'd1;
            n_tl     = tl_now;
            n_mode   = eff_mode;
            n_active = !done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc    <= 16'd0;
            r_idx    <= 15'd0;
            r_tl     <= 16'd0;
            r_mode   <= ipcs_pkg::MODE_IP;
            r_active <= 1'b0;
        end else begin
            r_acc    <= n_acc;
            r_idx    <= n_idx;
            r_tl     <= n_tl;
            r_mode   <= n_mode;
            r_active <= n_active;
        end
    end

endmodule

>>> sv/ip_packet_checksum_top.sv
// Top level of the IP packet checksum block: input register, checksum engine, result register.
// Path: a word accepted into the input register passes through the engine into the result register.
// Throughput: one packet word per cycle while the result register is not stalled; the engine's
// single add with end-around carry sits between the input register and the result register.
// Reset: synchronous, active low; both registers empty, engine idle with a zero sum.
module ip_packet_checksum_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_pkt_word,
    input  logic        i_first,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [15:0] o_checksum,
    output logic        o_length_error
);

    // Input register. It holds one transaction until the engine can take it.
    logic             r_in_valid;
    ipcs_pkg::t_item  r_in_item;

    // Result register.
    logic             r_out_valid;
    logic [15:0]      r_checksum;
    logic             r_length_error;

    ipcs_pkg::t_result engine_res;
    logic              advance;
    logic              in_take;

    // The engine steps whenever the result register is free or being emptied this cycle.
    // While a finished result waits, every held word stalls behind it, even one that
    // would produce nothing.
    assign advance    = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !advance;
    assign in_take    = i_in_valid && !o_in_stall;

    ipcs_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (r_in_valid && advance),
        .i_item  (r_in_item),
        .o_res   (engine_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_in_stall) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_item.func     <= i_func;
            r_in_item.pkt_word <= i_pkt_word;
            r_in_item.first    <= i_first;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= engine_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && engine_res.valid) begin
            r_checksum     <= engine_res.checksum;
            r_length_error <= engine_res.length_error;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_checksum     = r_checksum;
    assign o_length_error = r_length_error;

    // A short length result always carries a zero checksum.
    a_short_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_length_error |-> o_checksum == 16'd0)
        else $error("length error result with non-zero checksum");

    // The input side only stalls while a transaction is actually held.
    a_stall_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid)
        else $error("input stalled with an empty input register");

    // A held transaction that cannot advance is still there next cycle.
    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid)
        else $error("held transaction lost while stalled");

    // A result is only produced when the engine stepped on a held transaction.
    a_res_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        engine_res.valid |-> r_in_valid)
        else $error("engine result without an input transaction");

endmodule

>>> tb/testbench.sv
// Self-checking testbench for the IP packet checksum block, with its checksum scoreboard.
module testbench;

    // The scoreboard predicts the checksum engine word by word and holds the sums still due.
    typedef struct {
        logic [15:0] checksum;
        logic        length_error;
    } t_sum_result;

    class checksum_scoreboard;
        ipcs_pkg::t_mode mode      = ipcs_pkg::MODE_IP;
        logic   [15:0]   sum       = 16'h0000;
        logic   [14:0]   word_idx  = 15'd0;
        logic   [15:0]   total_len = 16'h0000;
        bit              busy      = 1'b0;
        t_sum_result     due_sums[$];
        int              errors    = 0;

        function void push_sum(logic [15:0] cs, logic len_err);
            t_sum_result r;
            r.checksum     = cs;
            r.length_error = len_err;
            due_sums.push_back(r);
        endfunction

        function int pending();
            return due_sums.size();
        endfunction

        // Advances the predicted engine by one accepted input transaction.
        function void note_word(ipcs_pkg::t_mode f, logic [15:0] w, logic opens);
            int unsigned last_idx;
            int unsigned first_idx;
            bit          transport;
            logic [15:0] v;
            logic [16:0] s;
            if (opens) begin
                mode      = f;
                sum       = 16'h0000;
                word_idx  = 15'd0;
                total_len = 16'h0000;
                busy      = 1'b1;
            end
            if (!busy)
                return;
            if (word_idx == ipcs_pkg::IDX_LEN_WORD) begin
                total_len = w;
                if (w < ipcs_pkg::MIN_LEN) begin
                    push_sum(16'h0000, 1'b1);
                    busy = 1'b0;
                    return;
                end
            end
            transport = (mode == ipcs_pkg::MODE_TCP) || (mode == ipcs_pkg::MODE_UDP);
            if (mode == ipcs_pkg::MODE_IP)
                last_idx = 32'(ipcs_pkg::IDX_IP_LAST);
            else
                last_idx = ((32'(total_len) + 32'd1) >> 1) - 32'd1;
            first_idx = transport ? 32'(ipcs_pkg::IDX_PROTO) : 32'd0;
            if (word_idx >= first_idx && (word_idx == 0 || word_idx <= last_idx)) begin
                v = w;
                if (transport && word_idx == ipcs_pkg::IDX_PROTO)
                    v = (mode == ipcs_pkg::MODE_TCP) ? ipcs_pkg::PROTO_TCP
                                                     : ipcs_pkg::PROTO_UDP;
                else if (transport && word_idx == ipcs_pkg::IDX_PSEUDO_L)
                    v = total_len - ipcs_pkg::MIN_LEN;
                if (word_idx >= 1 && word_idx == last_idx && mode != ipcs_pkg::MODE_IP
                        && total_len[0])
                    v = v & ipcs_pkg::PAD_MASK;
                s   = {1'b0, sum} + {1'b0, v};
                sum = s[15:0] + {15'd0, s[16]};
            end
            if (word_idx >= 1 && word_idx == last_idx) begin
                push_sum(~sum, 1'b0);
                busy = 1'b0;
                return;
            end
            word_idx = word_idx + 15'd1;
        endfunction

        // Compares one accepted output transaction with the oldest sum still due.
        function void check_sum(logic [15:0] cs, logic len_err);
            t_sum_result e;
            if (due_sums.size() == 0) begin
                $display("%0t: unexpected result, checksum %h length_error %b",
                         $time, cs, len_err);
                errors++;
                return;
            end
            e = due_sums.pop_front();
            if (cs !== e.checksum) begin
                $display("%0t: checksum mismatch, expected %h, actual %h",
                         $time, e.checksum, cs);
                errors++;
            end
            if (len_err !== e.length_error) begin
                $display("%0t: length_error mismatch, expected %b, actual %b",
                         $time, e.length_error, len_err);
                errors++;
            end
        endfunction
    endclass

    typedef enum int {
        FILL_RANDOM,
        FILL_ONES,
        FILL_ZEROS
    } t_fill;

    // Run shape. The long hold-off must stay well inside the watchdog limit, since the
    // block fills up during it and nothing moves on either side for most of it.
    localparam int RANDOM_ITEMS   = 600;
    localparam int HOLD_CYCLES    = 200;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [1:0]  i_func;
    logic [15:0] i_pkt_word;
    logic        i_first;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [15:0] o_checksum;
    logic        o_length_error;

    checksum_scoreboard sb = new();

    // Shared between the stimulus and the result sink: the stimulus asks for the long
    // hold-off and chooses per packet whether either side runs without idling.
    bit tx_no_idle    = 1'b0;
    bit rx_no_idle    = 1'b0;
    bit long_hold_req = 1'b0;

    int items_sent   = 0;
    int stuck_cycles = 0;

    ip_packet_checksum_top dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_pkt_word     (i_pkt_word),
        .i_first        (i_first),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_checksum     (o_checksum),
        .o_length_error (o_length_error)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Offers one packet word after a random gap and holds it, unchanged, until the block
    // takes it. Valid is left high on return so that a following word with no gap keeps
    // the channel busy without valid dropping in between.
    task automatic send_word(input ipcs_pkg::t_mode f, input logic [15:0] w,
                             input logic opens);
        int gap;
        gap = tx_no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func     <= f;
        i_pkt_word <= w;
        i_first    <= opens;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note_word(f, w, opens);
    endtask

    // Sends the first n_words of a packet. Word 1 carries the total length; the mode on
    // later words is random, as the block is meant to sample it only on word 0.
    task automatic send_packet(input ipcs_pkg::t_mode m, input logic [15:0] len,
                               input int n_words, input t_fill fill);
        logic [15:0] w;
        for (int k = 0; k < n_words; k++) begin
            if (k == 1)
                w = len;
            else if (fill == FILL_ONES)
                w = 16'hFFFF;
            else if (fill == FILL_ZEROS)
                w = 16'h0000;
            else
                w = 16'($urandom);
            send_word((k == 0) ? m : ipcs_pkg::t_mode'($urandom_range(0, 3)), w, k == 0);
            items_sent++;
        end
    endtask

    // Stops offering words until every predicted sum has come out, then lets the block settle.
    task automatic wait_for_sums();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Result sink. After each accepted result it stalls for a random number of cycles,
    // unless asked to run without idling; on request it holds the output off for a long
    // stretch so that results back up and the block stalls its input.
    initial begin : result_sink
        int hold;
        i_out_stall = 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_out_stall <= 1'b0;
            end else if (i_rst_n && o_out_valid && !i_out_stall) begin
                hold = rx_no_idle ? 0 : $urandom_range(0, 4);
                if (hold > 0) begin
                    i_out_stall <= 1'b1;
                    repeat (hold) @(posedge i_clk);
                    i_out_stall <= 1'b0;
                end
            end
        end
    end

    // Every output transaction is checked against the scoreboard at the edge that takes it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_sum(o_checksum, o_length_error);
    end

    // The watchdog ends a run in which neither channel has moved for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            stuck_cycles = 0;
        else
            stuck_cycles++;
        if (stuck_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin : stimulus
        int              pkt_no;
        int              kind;
        int              n_words;
        ipcs_pkg::t_mode m;
        t_fill           fill;
        logic [15:0]     len;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_func     = ipcs_pkg::MODE_IP;
        i_pkt_word = 16'h0000;
        i_first    = 1'b0;
        pkt_no     = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. A stray word while idle must be ignored.
        send_word(ipcs_pkg::MODE_ICMP, 16'hA5A5, 1'b0);
        // A zero total length and one just below the minimum are both flagged at word 1.
        send_packet(ipcs_pkg::MODE_IP, 16'd0, 2, FILL_ZEROS);
        send_packet(ipcs_pkg::MODE_UDP, 16'd19, 2, FILL_ONES);
        // A TCP packet abandoned after its length word; the next start mark restarts.
        send_packet(ipcs_pkg::MODE_TCP, 16'd40, 2, FILL_RANDOM);
        // Odd length with all ones: the pad byte of the last word has to be cleared.
        send_packet(ipcs_pkg::MODE_ICMP, 16'd21, 11, FILL_ONES);
        // A word past the end of a packet yields nothing.
        send_word(ipcs_pkg::MODE_IP, 16'hFFFF, 1'b0);
        // Shortest TCP packet: the pseudo header length word becomes zero.
        send_packet(ipcs_pkg::MODE_TCP, 16'd20, 10, FILL_RANDOM);
        // The sender pauses here until every sum has come back.
        wait_for_sums();

        // Random part. Most packets are well formed with random content; the rest are
        // short-length errors, abandoned packets and stray trailing words.
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS) begin
            pkt_no++;
            tx_no_idle = ($urandom_range(0, 5) == 0);
            rx_no_idle = ($urandom_range(0, 5) == 0);
            if (pkt_no == 3)
                long_hold_req = 1'b1;
            if (pkt_no == 15)
                wait_for_sums();
            m    = ipcs_pkg::t_mode'($urandom_range(0, 3));
            fill = ($urandom_range(0, 7) == 0) ? t_fill'($urandom_range(1, 2)) : FILL_RANDOM;
            kind = $urandom_range(0, 9);
            if (kind == 0)
                len = 16'($urandom_range(0, 19));
            else if (kind == 1)
                len = 16'($urandom_range(20, 21));
            else
                len = 16'($urandom_range(20, 80));
            n_words = (int'(len) + 1) / 2;
            if (kind == 0)
                n_words = 2;
            else if (kind == 2)
                n_words = $urandom_range(1, n_words - 1);
            send_packet(m, len, n_words, fill);
            if ($urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, 3))
                    send_word(ipcs_pkg::t_mode'($urandom_range(0, 3)), 16'($urandom), 1'b0);
        end

        // A packet of the largest total length, abandoned after a few words: the pseudo header
        // length word is still exercised, but the last word with its pad byte is never reached.
        tx_no_idle = 1'b0;
        rx_no_idle = 1'b0;
        send_packet(ipcs_pkg::MODE_UDP, 16'hFFFF, 12, FILL_RANDOM);
        send_word(ipcs_pkg::MODE_ICMP, 16'($urandom), 1'b0);

        wait_for_sums();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
sv/ipcs_pkg.sv
sv/ipcs_engine.sv
sv/ip_packet_checksum_top.sv
tb/testbench.sv
